### rtl/core/cgm_pkg.sv
// cgm_pkg: shared types, codes and defaults for the complex tile multiply block
// no dependencies; imported by every module in rtl/core
package cgm_pkg;

  localparam int DEF_TILE_ROWS = 4;
  localparam int DEF_TILE_COLS = 4;
  localparam int DEF_ACC_WIDTH = 48;

  // operation codes carried in the input transaction
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD_A = 3'd1,
    OP_LOAD_B = 3'd2,
    OP_UPDATE = 3'd3,
    OP_MERGE  = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ALPHA_REAL = 2'd0,
    REG_ALPHA_IMAG = 2'd1,
    REG_BETA_REAL  = 2'd2,
    REG_BETA_IMAG  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cplx_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [15:0] value_real;
    logic signed [15:0] value_imag;
  } item_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [15:0] c_real;
    logic signed [15:0] c_imag;
  } result_t;

  // command token that walks along the cell chain
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_t;

endpackage

### rtl/core/cgm_cell.sv
// cgm_cell: one accumulator cell of the chain, holds one complex tile element
// depends on cgm_pkg (cplx_t, cmd_t, op_t)
module cgm_cell #(
  parameter int ACC_WIDTH = cgm_pkg::DEF_ACC_WIDTH,
  parameter int IDX_W     = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cgm_pkg::cmd_t               cmd_in,
  input  logic [IDX_W-1:0]            idx_in,
  input  logic signed [ACC_WIDTH-1:0] data_r_in,
  input  logic signed [ACC_WIDTH-1:0] data_i_in,
  input  cgm_pkg::cplx_t              a,
  input  cgm_pkg::cplx_t              b,
  output cgm_pkg::cmd_t               cmd_out,
  output logic [IDX_W-1:0]            idx_out,
  output logic signed [ACC_WIDTH-1:0] data_r_out,
  output logic signed [ACC_WIDTH-1:0] data_i_out
);
  import cgm_pkg::*;

  localparam int SUMW = ACC_WIDTH + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  cmd_t                        cmd_q;
  logic [IDX_W-1:0]            idx_q;
  logic signed [ACC_WIDTH-1:0] dr_q;
  logic signed [ACC_WIDTH-1:0] di_q;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic signed [ACC_WIDTH-1:0] acc_i;
  logic signed [31:0]          p_rr, p_ii, p_ri, p_ir;
  logic                        pend;
  logic signed [32:0]          term_r, term_i;
  logic signed [SUMW-1:0]      sum_r, sum_i;
  logic signed [ACC_WIDTH-1:0] acc_r_next, acc_i_next;
  logic                        hit;

  assign hit = cmd_q.valid && (cmd_q.op == OP_MERGE) && (idx_q == IDX_W'(CELL_IDX));

  assign cmd_out    = cmd_q;
  assign idx_out    = idx_q;
  assign data_r_out = hit ? acc_r : dr_q;
  assign data_i_out = hit ? acc_i : di_q;

  // complex product terms, then saturating accumulate
  assign term_r = 33'(p_rr) - 33'(p_ii);
  assign term_i = 33'(p_ri) + 33'(p_ir);
  assign sum_r  = SUMW'(acc_r) + SUMW'(term_r);
  assign sum_i  = SUMW'(acc_i) + SUMW'(term_i);

  always_comb begin
    acc_r_next = sum_r[ACC_WIDTH-1:0];
    acc_i_next = sum_i[ACC_WIDTH-1:0];
    if (sum_r[SUMW-1] != sum_r[SUMW-2]) begin
      acc_r_next = sum_r[SUMW-1] ? ACC_MIN : ACC_MAX;
    end
    if (sum_i[SUMW-1] != sum_i[SUMW-2]) begin
      acc_i_next = sum_i[SUMW-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '{valid: 1'b0, op: OP_CLEAR};
      pend  <= 1'b0;
      acc_r <= '0;
      acc_i <= '0;
    end else begin
      cmd_q <= cmd_in;
      pend  <= cmd_q.valid && (cmd_q.op == OP_UPDATE);
      if (cmd_q.valid && (cmd_q.op == OP_CLEAR)) begin
        acc_r <= '0;
        acc_i <= '0;
      end else if (pend) begin
        acc_r <= acc_r_next;
        acc_i <= acc_i_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= idx_in;
    dr_q  <= data_r_in;
    di_q  <= data_i_in;
    p_rr  <= 32'(a.re) * 32'(b.re);
    p_ii  <= 32'(a.im) * 32'(b.im);
    p_ri  <= 32'(a.re) * 32'(b.im);
    p_ir  <= 32'(a.im) * 32'(b.re);
  end

endmodule

### rtl/core/cgm_merge.sv
// cgm_merge: alpha*acc + beta*c_old, rounded half-up and saturated to q1.15
// depends on cgm_pkg (cplx_t)
module cgm_merge #(
  parameter int ACC_WIDTH = cgm_pkg::DEF_ACC_WIDTH
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic signed [ACC_WIDTH-1:0] acc_r,
  input  logic signed [ACC_WIDTH-1:0] acc_i,
  input  cgm_pkg::cplx_t              alpha,
  input  cgm_pkg::cplx_t              beta,
  input  cgm_pkg::cplx_t              c_old,
  output cgm_pkg::cplx_t              c_new
);
  import cgm_pkg::*;

  localparam int PW = ACC_WIDTH + 16;
  localparam int SW = ACC_WIDTH + 18;
  localparam logic signed [SW-1:0] Q_MAX = SW'(32767);
  localparam logic signed [SW-1:0] Q_MIN = SW'(-32768);
  localparam logic signed [SW-1:0] HALF  = SW'(1) <<< 29;

  logic signed [PW-1:0] m_rr, m_ii, m_ir, m_ri;
  logic signed [31:0]   b_rr, b_ii, b_ri, b_ir;
  logic signed [SW-1:0] sum_r, sum_i;

  function automatic logic signed [15:0] round_sat(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] sh;
    sh = (x + HALF) >>> 30;
    if (sh > Q_MAX) begin
      return 16'sh7fff;
    end else if (sh < Q_MIN) begin
      return 16'sh8000;
    end
    return sh[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      m_rr <= PW'(acc_r) * PW'(alpha.re);
      m_ii <= PW'(acc_i) * PW'(alpha.im);
      m_ir <= PW'(acc_i) * PW'(alpha.re);
      m_ri <= PW'(acc_r) * PW'(alpha.im);
      b_rr <= 32'(beta.re) * 32'(c_old.re);
      b_ii <= 32'(beta.im) * 32'(c_old.im);
      b_ri <= 32'(beta.re) * 32'(c_old.im);
      b_ir <= 32'(beta.im) * 32'(c_old.re);
    end
  end

  // old c term sits at 30 fraction bits, lifted to 45 to line up with alpha*acc
  assign sum_r = SW'(m_rr) - SW'(m_ii) + ((SW'(b_rr) - SW'(b_ii)) <<< 15);
  assign sum_i = SW'(m_ir) + SW'(m_ri) + ((SW'(b_ri) + SW'(b_ir)) <<< 15);

  assign c_new.re = round_sat(sum_r);
  assign c_new.im = round_sat(sum_i);

endmodule

### rtl/core/complex_gemm_microkernel.sv
// complex_gemm_microkernel: top level, C := beta*C + alpha*A*B over a tile of cells
// depends on cgm_pkg, cgm_cell, cgm_merge
// load A / load B: taken while idle, the block stays idle, no result
// clear, update, in-tile merge: a token walks the TILE_ROWS*TILE_COLS cells one a cycle;
// merge results pass the merge registers into the output register; not ready meanwhile
// reset: synchronous, clears accumulators, control and alpha=1-lsb, beta=0
module complex_gemm_microkernel #(
  parameter int TILE_ROWS = cgm_pkg::DEF_TILE_ROWS,
  parameter int TILE_COLS = cgm_pkg::DEF_TILE_COLS,
  parameter int ACC_WIDTH = cgm_pkg::DEF_ACC_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  // input transactions
  input  logic             item_valid,
  output logic             item_ready,
  input  cgm_pkg::item_t   item,
  // result transactions
  output logic             result_valid,
  input  logic             result_ready,
  output cgm_pkg::result_t result,
  // configuration writes
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);
  import cgm_pkg::*;

  localparam int CELLS = TILE_ROWS * TILE_COLS;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // one-hot sequencer: idle, token in the chain, last add / merge output
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t state;

  // configuration
  cplx_t alpha;
  cplx_t beta;

  // operand stores, undefined until loaded
  cplx_t a_column [TILE_ROWS];
  cplx_t b_row    [TILE_COLS];

  // latched merge transaction
  op_t        op_q;
  logic [1:0] row_q;
  logic [1:0] col_q;
  cplx_t      c_old_q;

  // chain wiring, entry at 0 and exit at CELLS
  cmd_t                        chain_cmd [CELLS+1];
  logic [IDX_W-1:0]            chain_idx [CELLS+1];
  logic signed [ACC_WIDTH-1:0] chain_dr  [CELLS+1];
  logic signed [ACC_WIDTH-1:0] chain_di  [CELLS+1];
  logic [CELLS-1:0]            cell_busy;

  logic    accept;
  logic    row_ok, col_ok;
  logic    launch;
  op_t     item_op;
  logic    out_free;
  logic    result_load;
  logic    merge_load;
  cplx_t   c_new;

  assign item_ready  = (state == ST_IDLE);
  assign accept      = item_valid && item_ready;
  assign item_op     = op_t'(item.operation);
  assign row_ok      = int'(item.row) < TILE_ROWS;
  assign col_ok      = int'(item.col) < TILE_COLS;
  assign out_free    = !result_valid || result_ready;
  // finished merge moves into the output register
  assign result_load = (state == ST_FINAL) && (op_q == OP_MERGE) && out_free;

  // clear and update always go down the chain; merge only when inside the tile
  always_comb begin
    launch = 1'b0;
    if (accept) begin
      case (item_op)
        OP_CLEAR:  launch = 1'b1;
        OP_UPDATE: launch = 1'b1;
        OP_MERGE:  launch = row_ok && col_ok;
        default:   launch = 1'b0;
      endcase
    end
  end

  assign chain_cmd[0] = '{valid: launch, op: item_op};
  assign chain_idx[0] = IDX_W'(int'(item.row) * TILE_COLS + int'(item.col));
  assign chain_dr[0]  = '0;
  assign chain_di[0]  = '0;

  // the cell chain, cell k holds tile element (k / TILE_COLS, k % TILE_COLS)
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    localparam int CROW = k / TILE_COLS;
    localparam int CCOL = k % TILE_COLS;

    cgm_cell #(
      .ACC_WIDTH (ACC_WIDTH),
      .IDX_W     (IDX_W),
      .CELL_IDX  (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd_in     (chain_cmd[k]),
      .idx_in     (chain_idx[k]),
      .data_r_in  (chain_dr[k]),
      .data_i_in  (chain_di[k]),
      .a          (a_column[CROW]),
      .b          (b_row[CCOL]),
      .cmd_out    (chain_cmd[k+1]),
      .idx_out    (chain_idx[k+1]),
      .data_r_out (chain_dr[k+1]),
      .data_i_out (chain_di[k+1])
    );

    assign cell_busy[k] = chain_cmd[k+1].valid;
  end

  // merge datapath picks up the accumulator carried out of the chain end
  assign merge_load = chain_cmd[CELLS].valid && (chain_cmd[CELLS].op == OP_MERGE);

  cgm_merge #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_merge (
    .clk   (clk),
    .load  (merge_load),
    .acc_r (chain_dr[CELLS]),
    .acc_i (chain_di[CELLS]),
    .alpha (alpha),
    .beta  (beta),
    .c_old (c_old_q),
    .c_new (c_new)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (launch) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (chain_cmd[CELLS].valid) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          // a finished merge waits here while the output register is full
          if (op_q != OP_MERGE) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.out_row <= row_q;
      result.out_col <= col_q;
      result.c_real  <= c_new.re;
      result.c_imag  <= c_new.im;
    end
  end

  // transaction fields kept for the merge
  always_ff @(posedge clk) begin
    if (launch) begin
      op_q       <= item_op;
      row_q      <= item.row;
      col_q      <= item.col;
      c_old_q.re <= item.value_real;
      c_old_q.im <= item.value_imag;
    end
  end

  // operand loads, out-of-tile indexes fall through
  always_ff @(posedge clk) begin
    for (int i = 0; i < TILE_ROWS; i++) begin
      if (accept && item_op == OP_LOAD_A && int'(item.row) == i) begin
        a_column[i].re <= item.value_real;
        a_column[i].im <= item.value_imag;
      end
    end
    for (int j = 0; j < TILE_COLS; j++) begin
      if (accept && item_op == OP_LOAD_B && int'(item.col) == j) begin
        b_row[j].re <= item.value_real;
        b_row[j].im <= item.value_imag;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha.re <= 16'sh7fff;
      alpha.im <= '0;
      beta.re  <= '0;
      beta.im  <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ALPHA_REAL: alpha.re <= cfg_wdata;
        REG_ALPHA_IMAG: alpha.im <= cfg_wdata;
        REG_BETA_REAL:  beta.re  <= cfg_wdata;
        REG_BETA_IMAG:  beta.im  <= cfg_wdata;
        default:        alpha.re <= alpha.re;
      endcase
    end
  end

`ifndef SYNTHESIS
  // only one token in the chain at a time
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_busy) <= 1)
    else $error("more than one command token in the cell chain");

  // a launched token leaves the chain after passing each cell's command register
  a_token_exit: assert property (@(posedge clk) disable iff (rst)
    launch |-> ##(CELLS) chain_cmd[CELLS].valid)
    else $error("command token did not reach the chain end in time");

  // the chain end only shows a token while the sequencer waits for it
  a_exit_in_run: assert property (@(posedge clk) disable iff (rst)
    chain_cmd[CELLS].valid |-> state == ST_RUN)
    else $error("token left the chain outside the run state");

  // a finished merge holds while the output register is still occupied
  a_merge_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && op_q == OP_MERGE && result_valid && !result_ready)
      |=> state == ST_FINAL)
    else $error("merge result dropped while output register full");
`endif

endmodule

### tb/sv/cgm_tile_check_pkg.sv
`timescale 1ns / 100ps
// cgm_tile_check_pkg: predictor and checker for the complex tile multiply block
// depends on cgm_pkg for the transaction structs, operation and register codes
package cgm_tile_check_pkg;
  import cgm_pkg::*;

  localparam int TROWS = DEF_TILE_ROWS;
  localparam int TCOLS = DEF_TILE_COLS;
  localparam int ACC_W = DEF_ACC_WIDTH;

  class tile_scoreboard;
    logic signed [15:0]      alpha_re, alpha_im, beta_re, beta_im;
    logic signed [15:0]      a_re [TROWS];
    logic signed [15:0]      a_im [TROWS];
    logic signed [15:0]      b_re [TCOLS];
    logic signed [15:0]      b_im [TCOLS];
    logic signed [ACC_W-1:0] acc_re [TROWS*TCOLS];
    logic signed [ACC_W-1:0] acc_im [TROWS*TCOLS];
    result_t                 c_elems_due [$];
    int                      errors;

    function new();
      alpha_re = 16'sh7fff;
      alpha_im = '0;
      beta_re  = '0;
      beta_im  = '0;
      foreach (acc_re[k]) begin
        acc_re[k] = '0;
        acc_im[k] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_ALPHA_REAL: alpha_re = val;
        REG_ALPHA_IMAG: alpha_im = val;
        REG_BETA_REAL:  beta_re  = val;
        REG_BETA_IMAG:  beta_im  = val;
        default: ;
      endcase
    endfunction

    // accumulator add that clamps at the accumulator width
    function logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W-1:0] acc,
                                              logic signed [32:0] term);
      logic signed [ACC_W:0] s;
      s = acc + term;
      if (s[ACC_W] != s[ACC_W-1])
        return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
    endfunction

    // half-up rounding from 45 to 15 fraction bits, clamp to q1.15
    function logic signed [15:0] round_q15(logic signed [79:0] x);
      logic signed [79:0] y;
      y = (x + (80'sd1 <<< 29)) >>> 30;
      if (y > 80'sd32767) return 16'sh7fff;
      if (y < -80'sd32768) return 16'sh8000;
      return y[15:0];
    endfunction

    function void take_item(item_t it);
      logic signed [15:0] vr, vi;
      logic signed [32:0] t_re, t_im;
      logic signed [79:0] s_re, s_im;
      result_t            c_new;
      int                 k;
      vr = it.value_real;
      vi = it.value_imag;
      case (it.operation)
        OP_CLEAR: begin
          foreach (acc_re[j]) begin
            acc_re[j] = '0;
            acc_im[j] = '0;
          end
        end
        OP_LOAD_A: begin
          a_re[it.row] = vr;
          a_im[it.row] = vi;
        end
        OP_LOAD_B: begin
          b_re[it.col] = vr;
          b_im[it.col] = vi;
        end
        OP_UPDATE: begin
          for (int r = 0; r < TROWS; r++) begin
            for (int c = 0; c < TCOLS; c++) begin
              k = r * TCOLS + c;
              t_re = a_re[r] * b_re[c] - a_im[r] * b_im[c];
              t_im = a_re[r] * b_im[c] + a_im[r] * b_re[c];
              acc_re[k] = sat_acc(acc_re[k], t_re);
              acc_im[k] = sat_acc(acc_im[k], t_im);
            end
          end
        end
        OP_MERGE: begin
          k = it.row * TCOLS + it.col;
          // beta of zero makes the old c term vanish on its own
          s_re = acc_re[k] * alpha_re - acc_im[k] * alpha_im
               + ((beta_re * vr - beta_im * vi) <<< 15);
          s_im = acc_im[k] * alpha_re + acc_re[k] * alpha_im
               + ((beta_re * vi + beta_im * vr) <<< 15);
          c_new.out_row = it.row;
          c_new.out_col = it.col;
          c_new.c_real  = round_q15(s_re);
          c_new.c_imag  = round_q15(s_im);
          c_elems_due.push_back(c_new);
        end
        default: ;
      endcase
    endfunction

    function void check_c_elem(result_t got);
      result_t want;
      if (c_elems_due.size() == 0) begin
        $display("%0t: unexpected c element (%0d,%0d) %0d %0d", $time, got.out_row,
                 got.out_col, $signed(got.c_real), $signed(got.c_imag));
        errors++;
        return;
      end
      want = c_elems_due.pop_front();
      if (got.out_row != want.out_row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, want.out_row, got.out_row);
        errors++;
      end
      if (got.out_col != want.out_col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, want.out_col, got.out_col);
        errors++;
      end
      if (got.c_real != want.c_real) begin
        $display("%0t: c_real at (%0d,%0d) expected %0d actual %0d", $time, want.out_row,
                 want.out_col, $signed(want.c_real), $signed(got.c_real));
        errors++;
      end
      if (got.c_imag != want.c_imag) begin
        $display("%0t: c_imag at (%0d,%0d) expected %0d actual %0d", $time, want.out_row,
                 want.out_col, $signed(want.c_imag), $signed(got.c_imag));
        errors++;
      end
    endfunction

    function int pending();
      return c_elems_due.size();
    endfunction

    function void report_leftover();
      if (c_elems_due.size() != 0) begin
        $display("%0t: %0d c elements never produced", $time, c_elems_due.size());
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_complex_gemm_microkernel.sv
`timescale 1ns / 100ps
// tb_complex_gemm_microkernel: self-checking bench for the complex tile multiply block
// depends on cgm_pkg, cgm_tile_check_pkg and the rtl of complex_gemm_microkernel
module tb_complex_gemm_microkernel;
  import cgm_pkg::*;
  import cgm_tile_check_pkg::*;

  // clear, update and merge walk a chain of cells, so allow two chain passes
  localparam int SETTLE_CYCLES = 2 * (DEF_TILE_ROWS * DEF_TILE_COLS + 2) + 4;
  // far above the worst gap: chain pass, sender gap, receiver stall, settle pause
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 130;
  localparam int PHASES        = 8;
  // a short run of full-scale rank-1 updates to build large accumulators of both signs
  localparam int SOAK_UPDATES  = 24;
  // operation codes the block must ignore
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  tile_scoreboard board;
  bit gaps_on = 1'b1;      // random idle bursts on both sides
  int stall_left = 0;
  int quiet_cycles = 0;
  int phase_items = 0;

  always #5 clk = ~clk;

  complex_gemm_microkernel dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // q1.15 operand: extremes, small values near zero, or anything at all
  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; valid stays up into the next call unless a gap is taken
  task automatic send(input logic [2:0] op, input logic [1:0] r, input logic [1:0] c,
                      input logic [15:0] vr, input logic [15:0] vi);
    item_t it;
    it.operation  = op;
    it.row        = r;
    it.col        = c;
    it.value_real = vr;
    it.value_imag = vi;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    board.take_item(it);
    if (op <= OP_MERGE) phase_items++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_any(input logic [2:0] op);
    send(op, 2'($urandom), 2'($urandom), pick_q15(), pick_q15());
  endtask

  // wait until every c element is back, then let a trailing chain pass finish
  task automatic settle();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // all four scale registers back to back, block idle
  task automatic set_scales(input logic [15:0] ar, input logic [15:0] ai,
                            input logic [15:0] br, input logic [15:0] bi);
    write_reg(REG_ALPHA_REAL, ar);
    write_reg(REG_ALPHA_IMAG, ai);
    write_reg(REG_BETA_REAL, br);
    write_reg(REG_BETA_IMAG, bi);
    cfg_wr_en <= 1'b0;
  endtask

  // well-formed tile pass: optional clear, reload some of a and b, update, merge
  task automatic tile_pass();
    int n;
    if ($urandom_range(0, 1) == 1) send_any(OP_CLEAR);
    n = $urandom_range(0, 4);
    repeat (n) send_any(OP_LOAD_A);
    n = $urandom_range(0, 4);
    repeat (n) send_any(OP_LOAD_B);
    n = $urandom_range(1, 3);
    repeat (n) send_any(OP_UPDATE);
    n = $urandom_range(1, 4);
    repeat (n) send_any(OP_MERGE);
  endtask

  // result side: check every accepted transaction, stall in short bursts
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) board.check_c_elem(result);
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles in which nothing moves on any port
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL complex_gemm_microkernel");
    $finish;
  end

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset scales, every a and b entry written before any update
    send(OP_LOAD_A, 2'd0, 2'd0, 16'h8000, 16'h7fff);
    send(OP_LOAD_A, 2'd1, 2'd0, 16'h7fff, 16'h8000);
    send(OP_LOAD_A, 2'd2, 2'd0, 16'h0000, 16'hffff);
    send(OP_LOAD_A, 2'd3, 2'd0, 16'h0001, 16'h0000);
    send(OP_LOAD_B, 2'd0, 2'd0, 16'h8000, 16'h8000);
    send(OP_LOAD_B, 2'd0, 2'd1, 16'h7fff, 16'h7fff);
    send(OP_LOAD_B, 2'd0, 2'd2, 16'hffff, 16'h0001);
    send(OP_LOAD_B, 2'd0, 2'd3, 16'h3039, 16'hc0de);
    send(OP_UPDATE, 2'd0, 2'd0, 16'h0000, 16'h0000);
    // beta is zero here, so the old c values must have no effect
    send(OP_MERGE, 2'd0, 2'd0, 16'h7fff, 16'h8000);
    send(OP_MERGE, 2'd3, 2'd3, 16'h8000, 16'h7fff);
    send(OP_MERGE, 2'd1, 2'd2, 16'h1234, 16'hedcb);
    // spare operation codes: ignored, no result
    send(OP_SPARE_FIRST, 2'd3, 2'd3, 16'h7fff, 16'h8000);
    send(3'(OP_SPARE_FIRST + 3'd1), 2'd0, 2'd1, 16'h8000, 16'h7fff);
    send(OP_SPARE_LAST, 2'd2, 2'd0, 16'hffff, 16'hffff);
    send(OP_CLEAR, 2'd3, 2'd3, 16'hffff, 16'hffff);
    send(OP_MERGE, 2'd2, 2'd1, 16'h7fff, 16'h7fff);
    send(OP_UPDATE, 2'd0, 2'd0, 16'h0000, 16'h0000);
    send(OP_UPDATE, 2'd3, 2'd3, 16'hffff, 16'hffff);
    send(OP_MERGE, 2'd3, 2'd0, 16'h0000, 16'h0000);

    // full-scale soak: large accumulators of both signs, then read every cell
    settle();
    gaps_on = 1'b0;
    set_scales(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send(OP_CLEAR, 2'd0, 2'd0, 16'h0000, 16'h0000);
    send(OP_LOAD_A, 2'd0, 2'd0, 16'h8000, 16'h8000);
    send(OP_LOAD_A, 2'd1, 2'd0, 16'h7fff, 16'h7fff);
    send(OP_LOAD_A, 2'd2, 2'd0, 16'h8000, 16'h7fff);
    send(OP_LOAD_A, 2'd3, 2'd0, 16'h7fff, 16'h8000);
    send(OP_LOAD_B, 2'd0, 2'd0, 16'h8000, 16'h7fff);
    send(OP_LOAD_B, 2'd0, 2'd1, 16'h8000, 16'h8000);
    send(OP_LOAD_B, 2'd0, 2'd2, 16'h7fff, 16'h8000);
    send(OP_LOAD_B, 2'd0, 2'd3, 16'h7fff, 16'h7fff);
    repeat (SOAK_UPDATES) send(OP_UPDATE, 2'd0, 2'd0, 16'h0000, 16'h0000);
    for (int k = 0; k < TROWS * TCOLS; k++)
      send(OP_MERGE, 2'(k / TCOLS), 2'(k % TCOLS), 16'h0000, 16'h0000);
    // one more update, then read two cells again
    send(OP_UPDATE, 2'd0, 2'd0, 16'h0000, 16'h0000);
    send(OP_MERGE, 2'd1, 2'd0, 16'h0000, 16'h0000);
    send(OP_MERGE, 2'd0, 2'd1, 16'h0000, 16'h0000);
    send(OP_CLEAR, 2'd0, 2'd0, 16'h0000, 16'h0000);

    // random phases, each under its own alpha and beta, extremes included
    for (int p = 0; p < PHASES; p++) begin
      settle();
      gaps_on = (p < PHASES - 1);   // last phase runs flat out
      case (p)
        0: set_scales(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        1: set_scales(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        2: set_scales(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        3: set_scales(16'h0000, 16'h0000, 16'h8000, 16'h0000);
        5: set_scales(pick_q15(), pick_q15(), 16'h0000, pick_q15());
        7: set_scales(16'h8000, 16'h7fff, 16'h0000, 16'h0000);
        default: set_scales(pick_q15(), pick_q15(), pick_q15(), pick_q15());
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          tile_pass();
        else
          send_any(3'($urandom_range(0, 7)));   // noise, spare codes included
      end
    end

    settle();
    board.report_leftover();
    if (board.errors == 0)
      $display("PASS complex_gemm_microkernel");
    else
      $display("FAIL complex_gemm_microkernel");
    $finish;
  end

endmodule
